/* rtl/gpbc_pkg.sv */
// Package for the pulse/blink pin controller: operation, action and mode
// codes, the result struct and the level-update helper.
// No dependencies.
`timescale 1ns / 1ps

package gpbc_pkg;

  // Default widths of the timing and cycle counters
  localparam int DEF_TIME_BITS  = 16;
  localparam int DEF_COUNT_BITS = 16;

  // Tick period in microseconds; a 1 ms tick gives a time scale of one
  localparam int TICK_PERIOD_US = 1000;
  localparam int TICK_SCALE     = TICK_PERIOD_US / 1000;

  // Field widths of the item ports
  localparam int OP_W     = 3;
  localparam int ACTION_W = 2;
  localparam int FIELD_W  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_STATIC = 3'd1,
    OP_PULSE  = 3'd2,
    OP_BLINK  = 3'd3,
    OP_ABORT  = 3'd4
  } op_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RESET   = 2'd0,
    ACT_SET     = 2'd1,
    ACT_TOGGLE  = 2'd2,
    ACT_INVALID = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_STATIC = 2'd0,
    MODE_PULSE  = 2'd1,
    MODE_BLINK  = 2'd2
  } mode_t;

  // One result item
  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic status;
  } gpbc_result_t;

  // Apply an action to the logical level
  function automatic logic apply_action(action_t act, logic lvl);
    logic res;
    case (act)
      ACT_RESET:  res = 1'b0;
      ACT_SET:    res = 1'b1;
      ACT_TOGGLE: res = ~lvl;
      default:    res = lvl;
    endcase
    return res;
  endfunction

endpackage

/* rtl/gpbc_core.sv */
// Sequence state and next-state logic of the pulse/blink pin controller.
// Updates the state on accepted items and forms each accepted item's result.
// Depends on gpbc_pkg.
`timescale 1ns / 1ps

module gpbc_core #(
  parameter int TIME_BITS  = gpbc_pkg::DEF_TIME_BITS,
  parameter int COUNT_BITS = gpbc_pkg::DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [gpbc_pkg::OP_W-1:0]     op,
  input  logic [gpbc_pkg::ACTION_W-1:0] action,
  input  logic [gpbc_pkg::FIELD_W-1:0]  start_delay,
  input  logic [gpbc_pkg::FIELD_W-1:0]  active_ticks,
  input  logic [gpbc_pkg::FIELD_W-1:0]  inactive_ticks,
  input  logic [gpbc_pkg::FIELD_W-1:0]  blink_count,
  input  logic                          polarity,
  output gpbc_pkg::gpbc_result_t        result,
  output logic                          idle
);
  import gpbc_pkg::*;

  localparam int EL_BITS = TIME_BITS + 1;

  // State registers
  logic                  logical_level, logical_level_next;
  logic                  resting_level, resting_level_next;
  action_t               pending_action, pending_action_next;
  mode_t                 run_mode, run_mode_next;
  logic [TIME_BITS-1:0]  delay_left, delay_left_next;
  logic [EL_BITS-1:0]    elapsed_ticks, elapsed_ticks_next;
  logic [TIME_BITS-1:0]  active_length, active_length_next;
  logic [TIME_BITS-1:0]  inactive_length, inactive_length_next;
  logic [COUNT_BITS-1:0] cycles_left, cycles_left_next;
  logic                  endless, endless_next;
  logic                  first_step, first_step_next;
  logic                  in_active_phase, in_active_phase_next;
  logic                  idle_next;
  logic                  status_next;

  // Next state for one item
  always_comb begin
    logic [EL_BITS-1:0]    el;
    logic [COUNT_BITS-1:0] cyc;
    logic [COUNT_BITS-1:0] cnt_in;
    logic                  lvl;
    logic                  rest;
    logic                  flip;
    action_t               pact;

    logical_level_next   = logical_level;
    resting_level_next   = resting_level;
    pending_action_next  = pending_action;
    run_mode_next        = run_mode;
    delay_left_next      = delay_left;
    elapsed_ticks_next   = elapsed_ticks;
    active_length_next   = active_length;
    inactive_length_next = inactive_length;
    cycles_left_next     = cycles_left;
    endless_next         = endless;
    first_step_next      = first_step;
    in_active_phase_next = in_active_phase;
    idle_next            = idle;
    status_next          = 1'b0;

    el     = '0;
    cyc    = '0;
    cnt_in = COUNT_BITS'(blink_count);
    lvl    = logical_level;
    rest   = 1'b0;
    flip   = 1'b0;
    pact   = pending_action;

    if (accept) begin
      case (op_t'(op))
        OP_TICK: begin
          if (!idle) begin
            // Saturating elapsed count
            el = (elapsed_ticks == {EL_BITS{1'b1}}) ? elapsed_ticks
                                                     : elapsed_ticks + EL_BITS'(1);
            if (delay_left != '0 && el <= {1'b0, delay_left}) begin
              elapsed_ticks_next = el;
            end else begin
              delay_left_next = '0;
              case (run_mode)
                MODE_PULSE: begin
                  if (first_step) begin
                    lvl             = apply_action(pact, lvl);
                    first_step_next = 1'b0;
                    el              = '0;
                  end
                  if (el > {1'b0, active_length}) rest = 1'b1;
                end
                MODE_BLINK: begin
                  if (first_step) begin
                    lvl             = apply_action(pact, lvl);
                    pact            = ACT_TOGGLE;
                    first_step_next = 1'b0;
                    el              = '0;
                  end
                  if (in_active_phase && el > {1'b0, active_length}) begin
                    flip = 1'b1;
                  end else if (!in_active_phase && el > {1'b0, inactive_length}) begin
                    if (!endless) begin
                      cyc              = cycles_left - COUNT_BITS'(1);
                      cycles_left_next = cyc;
                      if (cyc == '0) rest = 1'b1;
                    end
                    if (!rest) flip = 1'b1;
                  end
                  if (flip) begin
                    lvl                  = apply_action(pact, lvl);
                    in_active_phase_next = ~in_active_phase;
                    el                   = '0;
                  end
                  pending_action_next = pact;
                end
                MODE_STATIC: begin
                  lvl                = apply_action(pact, lvl);
                  resting_level_next = lvl;
                  idle_next          = 1'b1;
                end
                default: begin
                end
              endcase
              elapsed_ticks_next = el;
              logical_level_next = lvl;
              // Drop back to the resting level and go idle
              if (rest) begin
                logical_level_next   = resting_level;
                pending_action_next  = resting_level ? ACT_SET : ACT_RESET;
                run_mode_next        = MODE_STATIC;
                active_length_next   = '0;
                inactive_length_next = '0;
                cycles_left_next     = '0;
                endless_next         = 1'b1;
                elapsed_ticks_next   = '0;
                first_step_next      = 1'b1;
                in_active_phase_next = 1'b1;
                idle_next            = 1'b1;
              end
            end
          end
        end
        OP_STATIC, OP_PULSE, OP_BLINK: begin
          if (action_t'(action) == ACT_INVALID) begin
            status_next = 1'b1;
          end else begin
            pending_action_next  = action_t'(action);
            delay_left_next      = TIME_BITS'(start_delay);
            elapsed_ticks_next   = '0;
            first_step_next      = 1'b1;
            in_active_phase_next = 1'b1;
            idle_next            = 1'b0;
            active_length_next   = '0;
            inactive_length_next = '0;
            cycles_left_next     = '0;
            endless_next         = 1'b1;
            run_mode_next        = MODE_STATIC;
            if (op_t'(op) == OP_PULSE) begin
              run_mode_next      = MODE_PULSE;
              active_length_next = TIME_BITS'(active_ticks);
            end else if (op_t'(op) == OP_BLINK) begin
              run_mode_next        = MODE_BLINK;
              active_length_next   = TIME_BITS'(active_ticks);
              inactive_length_next = TIME_BITS'(inactive_ticks);
              cycles_left_next     = cnt_in;
              endless_next         = (cnt_in == '0);
            end
          end
        end
        OP_ABORT: begin
          // Return to rest on the next tick
          if (!idle) begin
            pending_action_next  = resting_level ? ACT_SET : ACT_RESET;
            run_mode_next        = MODE_STATIC;
            delay_left_next      = '0;
            active_length_next   = '0;
            inactive_length_next = '0;
            cycles_left_next     = '0;
            endless_next         = 1'b1;
            elapsed_ticks_next   = '0;
            first_step_next      = 1'b1;
            in_active_phase_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result of the item, from the updated state
  always_comb begin
    result.pin_level = logical_level_next ^ ~polarity;
    result.busy_res  = ~idle_next;
    result.status    = status_next;
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      logical_level   <= 1'b0;
      resting_level   <= 1'b0;
      pending_action  <= ACT_RESET;
      run_mode        <= MODE_STATIC;
      delay_left      <= '0;
      elapsed_ticks   <= '0;
      active_length   <= '0;
      inactive_length <= '0;
      cycles_left     <= '0;
      endless         <= 1'b0;
      first_step      <= 1'b0;
      in_active_phase <= 1'b0;
      idle            <= 1'b1;
    end else begin
      logical_level   <= logical_level_next;
      resting_level   <= resting_level_next;
      pending_action  <= pending_action_next;
      run_mode        <= run_mode_next;
      delay_left      <= delay_left_next;
      elapsed_ticks   <= elapsed_ticks_next;
      active_length   <= active_length_next;
      inactive_length <= inactive_length_next;
      cycles_left     <= cycles_left_next;
      endless         <= endless_next;
      first_step      <= first_step_next;
      in_active_phase <= in_active_phase_next;
      idle            <= idle_next;
    end
  end

endmodule

/* rtl/gpio_pulse_blink_controller.sv */
// Pulse/blink pin controller, top level. Latency: a result item is valid
// the cycle after its input item is accepted. Throughput: one item per
// cycle unless an untaken result stalls; the state update is one pass of
// logic into the state registers; the output register reloads as drained.
// Reset (synchronous): idle, pin at logical 0, polarity 1, no result held.
// Depends on gpbc_pkg and gpbc_core.
`timescale 1ns / 1ps

module gpio_pulse_blink_controller #(
  parameter int TIME_BITS  = gpbc_pkg::DEF_TIME_BITS,
  parameter int COUNT_BITS = gpbc_pkg::DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gpbc_pkg::OP_W-1:0]     op,
  input  logic [gpbc_pkg::ACTION_W-1:0] action,
  input  logic [gpbc_pkg::FIELD_W-1:0]  start_delay,
  input  logic [gpbc_pkg::FIELD_W-1:0]  active_ticks,
  input  logic [gpbc_pkg::FIELD_W-1:0]  inactive_ticks,
  input  logic [gpbc_pkg::FIELD_W-1:0]  blink_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          pin_level,
  output logic                          busy_res,
  output logic                          status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);
  import gpbc_pkg::*;

  logic         in_fire;
  logic         polarity;
  logic         core_idle;
  gpbc_result_t core_res;
  gpbc_result_t res_q;

  assign in_ready  = ~out_valid | out_ready;
  assign in_fire   = in_valid & in_ready;
  assign cfg_ready = 1'b1;

  // Polarity register
  always_ff @(posedge clk) begin
    if (rst) begin
      polarity <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      polarity <= cfg_data;
    end
  end

  gpbc_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_fire),
    .op             (op),
    .action         (action),
    .start_delay    (start_delay),
    .active_ticks   (active_ticks),
    .inactive_ticks (inactive_ticks),
    .blink_count    (blink_count),
    .polarity       (polarity),
    .result         (core_res),
    .idle           (core_idle)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_q <= core_res;
    end
  end

  assign pin_level = res_q.pin_level;
  assign busy_res  = res_q.busy_res;
  assign status    = res_q.status;

  // Every accepted item yields a held result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted item produced no result");

  // A start with the invalid action is reported as rejected
  a_invalid_rejected: assert property (@(posedge clk) disable iff (rst)
    in_fire && (op == OP_STATIC || op == OP_PULSE || op == OP_BLINK) &&
    action == ACT_INVALID |=> status)
    else $error("invalid action start not rejected");

  // Abort while idle leaves the block idle
  a_abort_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire && op == OP_ABORT && core_idle |=> core_idle && !busy_res)
    else $error("abort while idle started a sequence");

endmodule
